// File: design/tevmidi_pkg.sv
// Shared types, codes and constants of the tracker event to MIDI encoder.
// Used by the front, queue and back modules and by the top level.
// No dependencies.
package tevmidi_pkg;

  typedef enum logic [2:0] {
    KIND_KEY_ON  = 3'd0,
    KIND_KEY_OFF = 3'd1,
    KIND_VOLUME  = 3'd2,
    KIND_PATCH   = 3'd3,
    KIND_BANK    = 3'd4,
    KIND_BEND    = 3'd5,
    KIND_CTRL    = 3'd6
  } kind_t;

  // Configuration register indexes.
  localparam logic [3:0] REG_LINEAR_VOLUME = 4'd0;
  localparam logic [3:0] REG_GLOBAL_VOLUME = 4'd1;

  // Status byte high nibbles.
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_BEND     = 4'hE;

  localparam logic [3:0] PERC_CHAN      = 4'd9;
  localparam logic [7:0] CC_BANK_SELECT = 8'd0;
  localparam logic [7:0] CC_VOLUME      = 8'd7;
  localparam logic [7:0] MAX_DATA       = 8'd127;
  localparam logic [7:0] UNKNOWN        = 8'd255;
  localparam logic [7:0] TRANSPOSE      = 8'd14;
  localparam logic [7:0] PATCH_LIMIT    = 8'd128;
  localparam logic [6:0] VOL_CLAMP      = 7'd63;
  localparam logic [6:0] GLOBAL_RESET   = 7'd64;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  volume;
    logic [7:0]  patch;
    logic [6:0]  bank;
    logic [13:0] bend;
    logic [6:0]  ctrl_number;
    logic [6:0]  ctrl_value;
  } event_t;

  // One event's worth of MIDI bytes, sent from byte 0 up.
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      count;
  } cmd_t;

  function automatic logic [6:0] vol_curve(input logic [5:0] lvl);
    logic [6:0] r;
    case (lvl)
      6'd0:  r = 7'h00; 6'd1:  r = 7'h01; 6'd2:  r = 7'h01; 6'd3:  r = 7'h01;
      6'd4:  r = 7'h01; 6'd5:  r = 7'h01; 6'd6:  r = 7'h01; 6'd7:  r = 7'h02;
      6'd8:  r = 7'h02; 6'd9:  r = 7'h03; 6'd10: r = 7'h04; 6'd11: r = 7'h04;
      6'd12: r = 7'h05; 6'd13: r = 7'h06; 6'd14: r = 7'h07; 6'd15: r = 7'h08;
      6'd16: r = 7'h09; 6'd17: r = 7'h0A; 6'd18: r = 7'h0B; 6'd19: r = 7'h0C;
      6'd20: r = 7'h0D; 6'd21: r = 7'h0F; 6'd22: r = 7'h10; 6'd23: r = 7'h11;
      6'd24: r = 7'h13; 6'd25: r = 7'h15; 6'd26: r = 7'h16; 6'd27: r = 7'h18;
      6'd28: r = 7'h1A; 6'd29: r = 7'h1C; 6'd30: r = 7'h1E; 6'd31: r = 7'h1F;
      6'd32: r = 7'h22; 6'd33: r = 7'h24; 6'd34: r = 7'h26; 6'd35: r = 7'h28;
      6'd36: r = 7'h2A; 6'd37: r = 7'h2D; 6'd38: r = 7'h2F; 6'd39: r = 7'h31;
      6'd40: r = 7'h34; 6'd41: r = 7'h37; 6'd42: r = 7'h39; 6'd43: r = 7'h3C;
      6'd44: r = 7'h3F; 6'd45: r = 7'h42; 6'd46: r = 7'h45; 6'd47: r = 7'h47;
      6'd48: r = 7'h4B; 6'd49: r = 7'h4E; 6'd50: r = 7'h51; 6'd51: r = 7'h54;
      6'd52: r = 7'h57; 6'd53: r = 7'h5B; 6'd54: r = 7'h5E; 6'd55: r = 7'h61;
      6'd56: r = 7'h64; 6'd57: r = 7'h69; 6'd58: r = 7'h6C; 6'd59: r = 7'h70;
      6'd60: r = 7'h74; 6'd61: r = 7'h78; 6'd62: r = 7'h7C; default: r = 7'h7F;
    endcase
    return r;
  endfunction

endpackage

// File: design/tevmidi_front.sv
// Front end: accepts events, keeps per-channel state and the configuration,
// and turns each event that yields bytes into a byte command for the queue. Uses tevmidi_pkg.
module tevmidi_front #(
  parameter int LOGICAL_CHANNELS = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 evt_valid,
  output logic                 evt_ready,
  input  tevmidi_pkg::event_t  evt,
  input  logic                 cfg_valid,
  input  logic [3:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output tevmidi_pkg::cmd_t    q_cmd
);

  localparam int IDXW = (LOGICAL_CHANNELS > 1) ? $clog2(LOGICAL_CHANNELS) : 1;

  logic [3:0] route_chan_r    [LOGICAL_CHANNELS];
  logic [6:0] perc_note_r     [LOGICAL_CHANNELS];
  logic [6:0] sounding_note_r [LOGICAL_CHANNELS];
  logic [7:0] cached_volume_r [LOGICAL_CHANNELS];
  logic [7:0] cached_patch_r  [LOGICAL_CHANNELS];
  logic [7:0] cached_bank_r   [LOGICAL_CHANNELS];

  logic       linear_volume_r;
  logic [6:0] global_volume_r;

  logic [IDXW-1:0] idx;
  logic            chan_ok;
  logic            accept;

  logic [3:0] rc, rc_nxt;
  logic [6:0] pn, pn_nxt;
  logic [6:0] sn, sn_nxt;
  logic [7:0] cv, cv_nxt;
  logic [7:0] cp, cp_nxt;
  logic [7:0] cb, cb_nxt;

  logic [3:0]  mel_chan;
  logic [13:0] vol_prod;
  logic [7:0]  vol_conv;
  logic [7:0]  note;
  logic [7:0]  key_sum;
  logic [7:0]  bank8;
  logic [7:0]  vol8;

  assign chan_ok   = evt.channel < 4'(LOGICAL_CHANNELS);
  assign idx       = evt.channel[IDXW-1:0];
  assign evt_ready = !q_full;
  assign accept    = evt_valid && evt_ready;

  assign rc = route_chan_r[idx];
  assign pn = perc_note_r[idx];
  assign sn = sounding_note_r[idx];
  assign cv = cached_volume_r[idx];
  assign cp = cached_patch_r[idx];
  assign cb = cached_bank_r[idx];

  assign mel_chan = (evt.channel > 4'd8) ? evt.channel + 4'd1 : evt.channel;
  assign key_sum  = {1'b0, evt.key} + tevmidi_pkg::TRANSPOSE;
  assign note     = (key_sum > tevmidi_pkg::MAX_DATA) ? tevmidi_pkg::MAX_DATA : key_sum;
  assign bank8    = {1'b0, evt.bank};
  assign vol8     = {1'b0, evt.volume};

  // Table curve scaled by the global volume, 64 being unity; linear mode is
  // 2*v below the clamp point and 127 at or above it.
  always_comb begin
    logic [5:0] lvl;
    lvl = (evt.volume > tevmidi_pkg::VOL_CLAMP) ? 6'd63 : evt.volume[5:0];
    vol_prod = {7'd0, tevmidi_pkg::vol_curve(lvl)} * {7'd0, global_volume_r};
    if (linear_volume_r) begin
      vol_conv = (evt.volume >= tevmidi_pkg::VOL_CLAMP) ? tevmidi_pkg::MAX_DATA
                                                        : {evt.volume, 1'b0};
    end else if (vol_prod[13:6] > tevmidi_pkg::MAX_DATA) begin
      vol_conv = tevmidi_pkg::MAX_DATA;
    end else begin
      vol_conv = vol_prod[13:6];
    end
  end

  always_comb begin
    logic [3:0] bank_chan;
    bank_chan = (pn != 7'd0) ? tevmidi_pkg::PERC_CHAN : mel_chan;
    q_cmd  = '0;
    rc_nxt = rc;
    pn_nxt = pn;
    sn_nxt = sn;
    cv_nxt = cv;
    cp_nxt = cp;
    cb_nxt = cb;
    unique case (evt.kind)
      tevmidi_pkg::KIND_KEY_ON: begin
        if (pn != 7'd0) begin
          rc_nxt = tevmidi_pkg::PERC_CHAN;
          sn_nxt = pn;
          cv_nxt = vol_conv;
          q_cmd.bytes[0] = {tevmidi_pkg::ST_NOTE_ON, tevmidi_pkg::PERC_CHAN};
          q_cmd.bytes[1] = {1'b0, pn};
          q_cmd.bytes[2] = vol_conv;
          q_cmd.count    = 3'd3;
        end else begin
          rc_nxt = mel_chan;
          sn_nxt = note[6:0];
          if (vol_conv != cv) begin
            // Volume change goes out on the previous route before the note.
            cv_nxt = vol_conv;
            q_cmd.bytes[0] = {tevmidi_pkg::ST_CTRL, rc};
            q_cmd.bytes[1] = tevmidi_pkg::CC_VOLUME;
            q_cmd.bytes[2] = vol_conv;
            q_cmd.bytes[3] = {tevmidi_pkg::ST_NOTE_ON, mel_chan};
            q_cmd.bytes[4] = note;
            q_cmd.bytes[5] = tevmidi_pkg::MAX_DATA;
            q_cmd.count    = 3'd6;
          end else begin
            q_cmd.bytes[0] = {tevmidi_pkg::ST_NOTE_ON, mel_chan};
            q_cmd.bytes[1] = note;
            q_cmd.bytes[2] = tevmidi_pkg::MAX_DATA;
            q_cmd.count    = 3'd3;
          end
        end
      end
      tevmidi_pkg::KIND_KEY_OFF: begin
        sn_nxt = 7'd0;
        q_cmd.bytes[0] = {tevmidi_pkg::ST_NOTE_OFF, rc};
        q_cmd.bytes[1] = {1'b0, sn};
        q_cmd.bytes[2] = 8'd0;
        q_cmd.count    = 3'd3;
        if (pn != 7'd0) begin
          q_cmd.bytes[3] = {tevmidi_pkg::ST_CTRL, tevmidi_pkg::PERC_CHAN};
          q_cmd.bytes[4] = tevmidi_pkg::CC_VOLUME;
          q_cmd.bytes[5] = tevmidi_pkg::MAX_DATA;
          q_cmd.count    = 3'd6;
        end
      end
      tevmidi_pkg::KIND_VOLUME: begin
        if (pn != 7'd0) begin
          cv_nxt = vol8;
          q_cmd.bytes[0] = {tevmidi_pkg::ST_CTRL, tevmidi_pkg::PERC_CHAN};
          q_cmd.bytes[1] = tevmidi_pkg::CC_VOLUME;
          q_cmd.bytes[2] = vol8;
          q_cmd.count    = 3'd3;
        end else if (vol_conv != cv) begin
          cv_nxt = vol_conv;
          q_cmd.bytes[0] = {tevmidi_pkg::ST_CTRL, rc};
          q_cmd.bytes[1] = tevmidi_pkg::CC_VOLUME;
          q_cmd.bytes[2] = vol_conv;
          q_cmd.count    = 3'd3;
        end
      end
      tevmidi_pkg::KIND_PATCH: begin
        if (evt.patch <= tevmidi_pkg::PATCH_LIMIT) begin
          pn_nxt = 7'd0;
          if (cp != evt.patch) begin
            cp_nxt = evt.patch;
            q_cmd.bytes[0] = {tevmidi_pkg::ST_PROGRAM, mel_chan};
            q_cmd.bytes[1] = {1'b0, evt.patch[6:0] - 7'd1};
            q_cmd.count    = 3'd2;
          end
        end else begin
          pn_nxt = evt.patch[6:0];
        end
      end
      tevmidi_pkg::KIND_BANK: begin
        if (cb != bank8) begin
          cb_nxt = bank8;
          cp_nxt = tevmidi_pkg::UNKNOWN;
          q_cmd.bytes[0] = {tevmidi_pkg::ST_CTRL, bank_chan};
          q_cmd.bytes[1] = tevmidi_pkg::CC_BANK_SELECT;
          q_cmd.bytes[2] = bank8;
          q_cmd.count    = 3'd3;
        end
      end
      tevmidi_pkg::KIND_BEND: begin
        q_cmd.bytes[0] = {tevmidi_pkg::ST_BEND, rc};
        q_cmd.bytes[1] = {1'b0, evt.bend[6:0]};
        q_cmd.bytes[2] = {1'b0, evt.bend[13:7]};
        q_cmd.count    = 3'd3;
      end
      tevmidi_pkg::KIND_CTRL: begin
        q_cmd.bytes[0] = {tevmidi_pkg::ST_CTRL, rc};
        q_cmd.bytes[1] = {1'b0, evt.ctrl_number};
        q_cmd.bytes[2] = {1'b0, evt.ctrl_value};
        q_cmd.count    = 3'd3;
      end
      default: begin
      end
    endcase
    if (!chan_ok) begin
      q_cmd.count = 3'd0;
    end
  end

  assign q_push = accept && (q_cmd.count != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      linear_volume_r <= 1'b0;
      global_volume_r <= tevmidi_pkg::GLOBAL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == tevmidi_pkg::REG_LINEAR_VOLUME) begin
        linear_volume_r <= cfg_data[0];
      end else if (cfg_index == tevmidi_pkg::REG_GLOBAL_VOLUME) begin
        global_volume_r <= cfg_data[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LOGICAL_CHANNELS; i++) begin
        route_chan_r[i]    <= '0;
        perc_note_r[i]     <= '0;
        sounding_note_r[i] <= '0;
        cached_volume_r[i] <= tevmidi_pkg::UNKNOWN;
        cached_patch_r[i]  <= tevmidi_pkg::UNKNOWN;
        cached_bank_r[i]   <= tevmidi_pkg::UNKNOWN;
      end
    end else if (accept && chan_ok) begin
      route_chan_r[idx]    <= rc_nxt;
      perc_note_r[idx]     <= pn_nxt;
      sounding_note_r[idx] <= sn_nxt;
      cached_volume_r[idx] <= cv_nxt;
      cached_patch_r[idx]  <= cp_nxt;
      cached_bank_r[idx]   <= cb_nxt;
    end
  end

endmodule

// File: design/tevmidi_queue.sv
// Two-entry command queue between the front end and the byte serializer.
// Uses tevmidi_pkg for the command type.
module tevmidi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tevmidi_pkg::cmd_t push_cmd,
  output logic              full,
  output logic              head_valid,
  output tevmidi_pkg::cmd_t head_cmd,
  input  logic              pop
);

  tevmidi_pkg::cmd_t slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

// File: design/tevmidi_back.sv
// Back end: sends the queue head through an output register, one byte
// per cycle unless stalled; marks each final byte. Uses tevmidi_pkg.
module tevmidi_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  tevmidi_pkg::cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       final_byte;

  assign load       = head_valid && (!valid_r || out_ready);
  assign final_byte = idx_r == (head_cmd.count - 3'd1);
  assign pop        = load && final_byte;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = final_byte ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_cmd.bytes[idx_r];
      last_r <= final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// File: design/tracker_event_to_midi_encoder.sv
// Channel   | Direction | Handshake            | Payload
// in_       | input     | in_tvalid/in_tready   | in_tdata (fields), in_tuser (kind)
// out_      | output    | out_tvalid/out_tready | out_tdata (MIDI byte), out_tlast
// cfg_      | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// An event is accepted when the two-entry command queue has room; it is
// written into the queue, and its first byte then goes to the output
// register. The serializer sends one byte per cycle while the output is not
// stalled; an event yields between 0 and 6 bytes of MIDI output.
// Reset is synchronous; per-channel state is held in flip-flops and is ready
// right after reset. A stalled output holds its byte; the front keeps taking
// events until the queue fills. cfg_ready is always high.
// Top level; depends on tevmidi_pkg, tevmidi_front, tevmidi_queue, tevmidi_back.
module tracker_event_to_midi_encoder #(
  parameter int LOGICAL_CHANNELS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] channel, [10:4] key, [17:11] volume, [25:18] patch, [32:26] bank,
  // [46:33] bend, [53:47] ctrl_number, [60:54] ctrl_value, [63:61] zero
  input  logic [63:0] in_tdata,
  // [2:0] kind
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] midi_byte
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tevmidi_pkg::event_t evt;
  tevmidi_pkg::cmd_t   push_cmd;
  tevmidi_pkg::cmd_t   head_cmd;
  logic                push;
  logic                full;
  logic                head_valid;
  logic                pop;

  assign evt.kind        = tevmidi_pkg::kind_t'(in_tuser);
  assign evt.channel     = in_tdata[3:0];
  assign evt.key         = in_tdata[10:4];
  assign evt.volume      = in_tdata[17:11];
  assign evt.patch       = in_tdata[25:18];
  assign evt.bank        = in_tdata[32:26];
  assign evt.bend        = in_tdata[46:33];
  assign evt.ctrl_number = in_tdata[53:47];
  assign evt.ctrl_value  = in_tdata[60:54];

  assign cfg_ready = 1'b1;

  tevmidi_front #(
    .LOGICAL_CHANNELS(LOGICAL_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .evt_valid(in_tvalid),
    .evt_ready(in_tready),
    .evt      (evt),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  tevmidi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  tevmidi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// File: design/tevmidi_chk.sv
// Port-level checker for the tracker event to MIDI encoder, bound to the top.
// Depends only on the top level's ports.
module tevmidi_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // High when the next output item opens a new event.
  logic first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      first_r <= out_tlast;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // Every event starts with a MIDI status byte.
  a_status_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && first_r |-> out_tdata[7])
    else $error("event does not open with a status byte");

endmodule

bind tracker_event_to_midi_encoder tevmidi_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
